/* rtl/core/vrt_pkg.sv */
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

    localparam int UNIT_BITS = 14;   // unit direction is Q2.14
    localparam int NORM_BITS = 8;    // extra scale from the radicand shift
    localparam int ACC_W     = 48;   // dividend / radicand width
    localparam int DVS_W     = 24;   // divisor width
    localparam int ROOT_W    = 24;
    localparam int REM_W     = 27;
    localparam int CNT_W     = 6;

    localparam logic [31:0] NEVER    = 32'hFFFF_FFFF;
    localparam logic [1:0]  NO_AXIS  = 2'd3;
    localparam logic [14:0] UNIT_ONE = 15'd16384;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [1:0] NRM_POS = 2'b01;
    localparam logic [1:0] NRM_NEG = 2'b11;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef struct packed {
        logic     go;
        iter_op_t op;
    } iter_req_t;

    typedef enum logic [1:0] {
        PH_SQRT,
        PH_UNIT,
        PH_DELTA,
        PH_CROSS
    } vrt_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_CHK,
        ST_ISSUE,
        ST_WAIT,
        ST_SETUP_END,
        ST_HIT,
        ST_EMIT
    } vrt_state_t;

endpackage

/* rtl/core/vrt_iter.sv */
// Shared radix-2 restoring divider / bitwise integer square root.
module vrt_iter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  vrt_pkg::iter_req_t          req,
    input  logic [vrt_pkg::ACC_W-1:0]   operand,
    input  logic [vrt_pkg::DVS_W-1:0]   divisor,
    output logic                        done,
    output logic [vrt_pkg::ACC_W-1:0]   result
);
    import vrt_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    iter_op_t          op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  cnt_last;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh   = {rem_reg[REM_W-3:0], acc_reg[ACC_W-1 -: 2]};
            trial    = REM_W'({root_reg, 2'b01});
            acc_next = {acc_reg[ACC_W-3:0], 2'b00};
            cnt_last = CNT_W'(ROOT_W - 1);
        end
        else
        begin
            rem_sh   = {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};
            trial    = REM_W'(dvs_reg);
            acc_next = {acc_reg[ACC_W-2:0], 1'b0};
            cnt_last = CNT_W'(ACC_W - 1);
        end
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[ROOT_W-2:0], ge};
        if (op_reg == OP_DIV)
        begin
            acc_next[0] = ge;   // quotient bit enters at the bottom
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == cnt_last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            acc_reg  <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_SQRT) ? ACC_W'(root_reg) : acc_reg;

endmodule

/* rtl/core/voxel_ray_traversal.sv */
// Voxel ray traversal top level: ray setup sequencer and cell walker.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | opcode, origin_x/y/z, dir_x/y/z, voxel_solid
//  out     | out_valid / out_ready | result_kind, cell_x/y/z, normal_x/y/z,
//          |                       | hit_distance, hit_pos_x/y/z
//  cfg     | cfg_valid / cfg_ready | cfg_data (reach_distance), always ready
//
// An answer beat that steps goes straight to the emit state; a hit first makes
// three passes through the one 16x32 multiplier for the hit point. A start beat
// squares the direction on the multiplier, then runs the root and, per axis, three
// divisions on the shared divider/square-root unit (24-bit root, 48-bit quotients),
// each via an issue and a wait state; a near-zero axis needs one division, not three.
// Reset clears all control state; no clearing pass is needed.
// in_ready is high only while the sequencer is idle. A finished result beat
// sits in the output register, so a new input beat can be taken while the
// previous result is still stalled by out_ready.
module voxel_ray_traversal
#(
    parameter int FRAC_BITS = 16,
    parameter int CELL_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input beats
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic               voxel_solid,
    // result beats
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         result_kind,
    output logic signed [15:0] cell_x,
    output logic signed [15:0] cell_y,
    output logic signed [15:0] cell_z,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y,
    output logic signed [1:0]  normal_z,
    output logic [23:0]        hit_distance,
    output logic signed [31:0] hit_pos_x,
    output logic signed [31:0] hit_pos_y,
    output logic signed [31:0] hit_pos_z,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);
    import vrt_pkg::*;

    localparam int CW = CELL_BITS;
    localparam int FW = FRAC_BITS;

    // ---------------- control state ----------------
    vrt_state_t  state_reg, state_next;
    vrt_phase_t  ph_reg;
    logic [1:0]  ax_reg;        // axis being set up / multiplied
    logic        mph_reg;       // multiply phase: 0 issue, 1 accumulate
    logic        active_reg;
    logic [23:0] reach_reg;
    logic [1:0]  last_reg;      // last stepped axis, NO_AXIS before the first step
    logic        out_valid_reg;

    // ---------------- ray state ----------------
    logic [31:0]        org_reg  [3];
    logic signed [15:0] dir_reg  [3];
    logic [CW-1:0]      cell_reg [3];
    logic [31:0]        nc_reg   [3];   // next boundary crossing distance
    logic [31:0]        dl_reg   [3];   // distance between crossings
    logic               sgn_reg  [3];   // 1 = negative step
    logic signed [15:0] udir_reg [3];   // unit direction, Q2.14
    logic [31:0]        trav_reg;
    logic [31:0]        s_reg;          // sum of squared direction
    logic [ROOT_W-1:0]  lenq_reg;
    logic [47:0]        mul_reg;
    logic [1:0]         nrm_reg  [3];
    logic [31:0]        pos_reg  [3];
    logic [1:0]         pend_kind_reg;

    // ---------------- output register ----------------
    logic [1:0]  o_kind_reg;
    logic [15:0] o_cell_reg [3];
    logic [1:0]  o_nrm_reg  [3];
    logic [23:0] o_dist_reg;
    logic [31:0] o_pos_reg  [3];

    // ---------------- combinational ----------------
    logic               in_fire;
    logic               emit_fire;
    logic [31:0]        org_in  [3];
    logic signed [15:0] dir_in  [3];
    logic [CW-1:0]      floor_in [3];

    logic signed [15:0] d_ax;
    logic signed [15:0] u_ax;
    logic [31:0]        org_ax;
    logic [15:0]        umag_ax;
    logic [FW:0]        gap_ax;

    iter_req_t          iter_req;
    logic [ACC_W-1:0]   iter_opnd;
    logic [DVS_W-1:0]   iter_dvs;
    logic               iter_done;
    logic [ACC_W-1:0]   iter_res;
    logic [14:0]        u_clamp;
    logic               u_small;
    logic [31:0]        q_sat;

    logic [15:0]        mul_a;
    logic [31:0]        mul_b;
    logic [47:0]        mul_p;
    logic [31:0]        hit_off;

    logic [1:0]         step_ax;
    logic [31:0]        nc_sel;
    logic [31:0]        dl_sel;
    logic [32:0]        nc_sum;
    logic [31:0]        nc_new;
    logic               step_miss;

    logic [FW:0]        best;
    logic [FW:0]        fr;
    logic [FW:0]        gp;
    logic [1:0]         sn   [3];
    logic [1:0]         hitn [3];

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic [15:0] cell_out(input logic [CW-1:0] c);
        return 16'(32'($signed(c)));
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = !out_valid_reg || out_ready;

    always_comb
    begin
        org_in[0] = origin_x;
        org_in[1] = origin_y;
        org_in[2] = origin_z;
        dir_in[0] = dir_x;
        dir_in[1] = dir_y;
        dir_in[2] = dir_z;
        for (int a = 0; a < 3; a++)
        begin
            floor_in[a] = CW'($signed(org_in[a]) >>> FW);
        end
    end

    // per-axis operands of the setup sequence
    assign d_ax    = dir_reg[ax_reg];
    assign u_ax    = udir_reg[ax_reg];
    assign org_ax  = org_reg[ax_reg];
    assign umag_ax = mag16(u_ax);
    assign gap_ax  = (u_ax > 16'sd0) ? (((FW+1)'(1) << FW) - {1'b0, org_ax[FW-1:0]})
                                     : {1'b0, org_ax[FW-1:0]};

    always_comb
    begin
        iter_req.go = (state_reg == ST_ISSUE);
        iter_req.op = (ph_reg == PH_SQRT) ? OP_SQRT : OP_DIV;
        iter_dvs    = DVS_W'(umag_ax);
        case (ph_reg)
            PH_SQRT:
            begin
                iter_opnd = {s_reg, 16'h0000};
                iter_dvs  = '0;
            end
            PH_UNIT:
            begin
                iter_opnd = (ACC_W'(mag16(d_ax)) << (UNIT_BITS + NORM_BITS))
                            + ACC_W'(lenq_reg >> 1);
                iter_dvs  = lenq_reg;
            end
            PH_DELTA: iter_opnd = ACC_W'(1) << (FW + UNIT_BITS);
            PH_CROSS: iter_opnd = ACC_W'(gap_ax) << UNIT_BITS;
            default:  iter_opnd = '0;
        endcase
    end

    vrt_iter u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (iter_req),
        .operand (iter_opnd),
        .divisor (iter_dvs),
        .done    (iter_done),
        .result  (iter_res)
    );

    assign u_clamp = (iter_res > ACC_W'(UNIT_ONE)) ? UNIT_ONE : iter_res[14:0];
    assign u_small = (u_clamp <= 15'd1);   // |u| * 10000 <= 1.0
    assign q_sat   = (|iter_res[ACC_W-1:32]) ? NEVER : iter_res[31:0];

    // shared multiplier: squares during setup, |u| * travelled for the hit point
    assign mul_a = (state_reg == ST_SQ) ? mag16(d_ax) : umag_ax;
    assign mul_b = (state_reg == ST_SQ) ? 32'(mag16(d_ax)) : trav_reg;
    assign mul_p = 48'(mul_a) * 48'(mul_b);

    // floor toward minus infinity for negative direction
    assign hit_off = u_ax[15] ? (32'd0 - 32'((mul_reg + 48'((1 << UNIT_BITS) - 1)) >> UNIT_BITS))
                              : 32'(mul_reg >> UNIT_BITS);

    // next axis to step: on ties z wins over y and x, and y wins over x
    always_comb
    begin
        if (nc_reg[0] < nc_reg[1] && nc_reg[0] < nc_reg[2])
        begin
            step_ax = 2'd0;
        end
        else if (nc_reg[1] < nc_reg[2])
        begin
            step_ax = 2'd1;
        end
        else
        begin
            step_ax = 2'd2;
        end
        case (step_ax)
            2'd0:    begin nc_sel = nc_reg[0]; dl_sel = dl_reg[0]; end
            2'd1:    begin nc_sel = nc_reg[1]; dl_sel = dl_reg[1]; end
            default: begin nc_sel = nc_reg[2]; dl_sel = dl_reg[2]; end
        endcase
        nc_sum    = {1'b0, nc_sel} + {1'b0, dl_sel};
        nc_new    = nc_sum[32] ? NEVER : nc_sum[31:0];
        step_miss = (nc_sel >= {8'h00, reach_reg});
    end

    // hit normal: nearest face in the start cell, else against the last step
    always_comb
    begin
        best  = {1'b0, org_reg[0][FW-1:0]};
        sn[0] = NRM_NEG;
        sn[1] = 2'b00;
        sn[2] = 2'b00;
        for (int a = 0; a < 3; a++)
        begin
            fr = {1'b0, org_reg[a][FW-1:0]};
            if (a > 0 && fr < best)
            begin
                best  = fr;
                sn[0] = 2'b00;
                sn[1] = 2'b00;
                sn[2] = 2'b00;
                sn[a] = NRM_NEG;
            end
            gp = ((FW+1)'(1) << FW) - fr;
            if (gp < best)
            begin
                best  = gp;
                sn[0] = 2'b00;
                sn[1] = 2'b00;
                sn[2] = 2'b00;
                sn[a] = NRM_POS;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            if (last_reg == NO_AXIS)
            begin
                hitn[a] = sn[a];
            end
            else if (last_reg == 2'(a))
            begin
                hitn[a] = sgn_reg[a] ? NRM_POS : NRM_NEG;
            end
            else
            begin
                hitn[a] = 2'b00;
            end
        end
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!opcode)
                    begin
                        state_next = ST_SQ;
                    end
                    else if (active_reg)
                    begin
                        state_next = voxel_solid ? ST_HIT : ST_EMIT;
                    end
                end
            end
            ST_SQ:
            begin
                if (mph_reg && ax_reg == 2'd2)
                begin
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK:    state_next = (s_reg == 32'd0) ? ST_EMIT : ST_ISSUE;
            ST_ISSUE:     state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (iter_done)
                begin
                    state_next = ST_ISSUE;
                    if (ax_reg == 2'd2 &&
                        ((ph_reg == PH_UNIT && u_small) || ph_reg == PH_CROSS))
                    begin
                        state_next = ST_SETUP_END;
                    end
                end
            end
            ST_SETUP_END: state_next = ST_EMIT;
            ST_HIT:
            begin
                if (mph_reg && ax_reg == 2'd2)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= PH_SQRT;
            ax_reg        <= 2'd0;
            mph_reg       <= 1'b0;
            active_reg    <= 1'b0;
            reach_reg     <= 24'd327680;
            last_reg      <= NO_AXIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                reach_reg <= cfg_data;
            end
            if (state_reg == ST_EMIT && emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        ax_reg  <= 2'd0;
                        mph_reg <= 1'b0;
                        if (!opcode || voxel_solid)
                        begin
                            active_reg <= 1'b0;
                        end
                        else if (active_reg)
                        begin
                            last_reg   <= step_ax;
                            active_reg <= !step_miss;
                        end
                    end
                end
                ST_SQ, ST_HIT:
                begin
                    mph_reg <= !mph_reg;
                    if (mph_reg)
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                ST_SQ_CHK:
                begin
                    ph_reg <= PH_SQRT;
                    ax_reg <= 2'd0;
                end
                ST_WAIT:
                begin
                    if (iter_done)
                    begin
                        case (ph_reg)
                            PH_SQRT:
                            begin
                                ph_reg <= PH_UNIT;
                                ax_reg <= 2'd0;
                            end
                            PH_UNIT:
                            begin
                                if (u_small)
                                begin
                                    ax_reg <= ax_reg + 2'd1;
                                end
                                else
                                begin
                                    ph_reg <= PH_DELTA;
                                end
                            end
                            PH_DELTA: ph_reg <= PH_CROSS;
                            default:
                            begin
                                ph_reg <= PH_UNIT;
                                ax_reg <= ax_reg + 2'd1;
                            end
                        endcase
                    end
                end
                ST_SETUP_END:
                begin
                    last_reg   <= NO_AXIS;
                    active_reg <= (reach_reg != 24'd0);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!opcode)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            org_reg[a]  <= org_in[a];
                            dir_reg[a]  <= dir_in[a];
                            cell_reg[a] <= floor_in[a];
                        end
                        s_reg <= 32'd0;
                    end
                    else if (active_reg && voxel_solid)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            nrm_reg[a] <= hitn[a];
                        end
                        pend_kind_reg <= KIND_HIT;
                    end
                    else if (active_reg)
                    begin
                        cell_reg[step_ax] <= sgn_reg[step_ax] ? cell_reg[step_ax] - CW'(1)
                                                              : cell_reg[step_ax] + CW'(1);
                        trav_reg        <= nc_sel;
                        nc_reg[step_ax] <= nc_new;
                        pend_kind_reg   <= step_miss ? KIND_MISS : KIND_QUERY;
                    end
                end
            end
            ST_SQ:
            begin
                if (!mph_reg)
                begin
                    mul_reg <= mul_p;
                end
                else
                begin
                    s_reg <= s_reg + mul_reg[31:0];
                end
            end
            ST_SQ_CHK:
            begin
                pend_kind_reg <= KIND_MISS;
            end
            ST_WAIT:
            begin
                if (iter_done)
                begin
                    case (ph_reg)
                        PH_SQRT:  lenq_reg <= iter_res[ROOT_W-1:0];
                        PH_UNIT:
                        begin
                            udir_reg[ax_reg] <= d_ax[15] ? -$signed({1'b0, u_clamp})
                                                         : $signed({1'b0, u_clamp});
                            sgn_reg[ax_reg]  <= d_ax[15] || (u_clamp == 15'd0);
                            if (u_small)
                            begin
                                dl_reg[ax_reg] <= NEVER;
                                nc_reg[ax_reg] <= NEVER;
                            end
                        end
                        PH_DELTA: dl_reg[ax_reg] <= q_sat;
                        default:  nc_reg[ax_reg] <= q_sat;
                    endcase
                end
            end
            ST_SETUP_END:
            begin
                trav_reg      <= 32'd0;
                pend_kind_reg <= (reach_reg == 24'd0) ? KIND_MISS : KIND_QUERY;
            end
            ST_HIT:
            begin
                if (!mph_reg)
                begin
                    mul_reg <= mul_p;
                end
                else
                begin
                    pos_reg[ax_reg] <= org_ax + hit_off;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    o_kind_reg <= pend_kind_reg;
                    o_dist_reg <= (pend_kind_reg == KIND_HIT) ? trav_reg[23:0] : 24'd0;
                    for (int a = 0; a < 3; a++)
                    begin
                        o_cell_reg[a] <= (pend_kind_reg != KIND_MISS) ? cell_out(cell_reg[a])
                                                                      : 16'd0;
                        o_nrm_reg[a]  <= (pend_kind_reg == KIND_HIT) ? nrm_reg[a] : 2'b00;
                        o_pos_reg[a]  <= (pend_kind_reg == KIND_HIT) ? pos_reg[a] : 32'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = o_kind_reg;
    assign cell_x       = o_cell_reg[0];
    assign cell_y       = o_cell_reg[1];
    assign cell_z       = o_cell_reg[2];
    assign normal_x     = o_nrm_reg[0];
    assign normal_y     = o_nrm_reg[1];
    assign normal_z     = o_nrm_reg[2];
    assign hit_distance = o_dist_reg;
    assign hit_pos_x    = o_pos_reg[0];
    assign hit_pos_y    = o_pos_reg[1];
    assign hit_pos_z    = o_pos_reg[2];

endmodule

/* tb/voxel_ray_traversal_chk.sv */
`timescale 1ns / 1ps
// Checker for the voxel ray walker: shadow model of the walk and beat-by-beat compare.
module voxel_ray_traversal_chk
    import vrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               opcode,
    input  logic [31:0]        origin_x,
    input  logic [31:0]        origin_y,
    input  logic [31:0]        origin_z,
    input  logic [15:0]        dir_x,
    input  logic [15:0]        dir_y,
    input  logic [15:0]        dir_z,
    input  logic               voxel_solid,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         result_kind,
    input  logic [15:0]        cell_x,
    input  logic [15:0]        cell_y,
    input  logic [15:0]        cell_z,
    input  logic [1:0]         normal_x,
    input  logic [1:0]         normal_y,
    input  logic [1:0]         normal_z,
    input  logic [23:0]        hit_distance,
    input  logic [31:0]        hit_pos_x,
    input  logic [31:0]        hit_pos_y,
    input  logic [31:0]        hit_pos_z,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 n_query,
    output int                 n_hit,
    output int                 n_miss
);

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] cells [3];
        logic [1:0]  nrm [3];
        logic [23:0] hit_dist;
        logic [31:0] pos [3];
    } walk_result_t;

    walk_result_t result_q [$];

    logic [23:0] reach;
    logic        active;
    logic [15:0] cur_cell [3];
    logic [31:0] next_x [3];
    logic [31:0] delta [3];
    logic        neg_step [3];
    logic [1:0]  prev_ax;
    logic [31:0] trav;
    logic [31:0] org [3];
    int          udir [3];

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_u32(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? NEVER : v[31:0];
    endfunction

    function automatic walk_result_t blank(input logic [1:0] kind);
        walk_result_t r;
        r.kind = kind;
        r.hit_dist = '0;
        for (int a = 0; a < 3; a++)
        begin
            r.cells[a] = '0;
            r.nrm[a]   = '0;
            r.pos[a]   = '0;
        end
        return r;
    endfunction

    task automatic push(input walk_result_t r);
        result_q.push_back(r);
    endtask

    task automatic predict_beat();
        longint signed   d [3];
        longint unsigned s;
        longint unsigned lenq;
        longint unsigned mag;
        longint unsigned u;
        longint unsigned gap;
        longint unsigned m;
        logic [31:0]     frac;
        logic [31:0]     off;
        logic [31:0]     best;
        logic [31:0]     g;
        walk_result_t    r;
        int              ax;
        if (!opcode)
        begin
            active = 1'b0;
            d[0] = $signed(dir_x);
            d[1] = $signed(dir_y);
            d[2] = $signed(dir_z);
            org[0] = origin_x;
            org[1] = origin_y;
            org[2] = origin_z;
            s = 0;
            for (int a = 0; a < 3; a++) s = s + longint'(d[a] * d[a]);
            if (s == 0)
            begin
                push(blank(KIND_MISS));
                return;
            end
            lenq = root64(s << 16);
            for (int a = 0; a < 3; a++)
            begin
                mag = (d[a] < 0) ? -d[a] : d[a];
                u = ((mag << (UNIT_BITS + NORM_BITS)) + (lenq >> 1)) / lenq;
                if (u > 16384) u = 16384;
                udir[a] = (d[a] < 0) ? -int'(u) : int'(u);
                neg_step[a] = !(udir[a] > 0);
                cur_cell[a] = org[a][31:16];
                frac = {16'd0, org[a][15:0]};
                if (u * 10000 <= 16384)
                begin
                    delta[a]  = NEVER;
                    next_x[a] = NEVER;
                end
                else
                begin
                    delta[a] = sat_u32((64'd1 << 30) / u);
                    gap = neg_step[a] ? frac : (64'd65536 - frac);
                    next_x[a] = sat_u32((gap << UNIT_BITS) / u);
                end
            end
            trav = 0;
            prev_ax = NO_AXIS;
            if (reach == 0)
            begin
                push(blank(KIND_MISS));
                return;
            end
            active = 1'b1;
            r = blank(KIND_QUERY);
            for (int a = 0; a < 3; a++) r.cells[a] = cur_cell[a];
            push(r);
            return;
        end
        // answer with no ray in flight: dropped silently
        if (!active) return;
        if (voxel_solid)
        begin
            r = blank(KIND_HIT);
            if (prev_ax == NO_AXIS)
            begin
                // nearest face of the start cell, strict improvement only
                r.nrm[0] = NRM_NEG;
                best = {16'd0, org[0][15:0]};
                for (int a = 0; a < 3; a++)
                begin
                    frac = {16'd0, org[a][15:0]};
                    if (a > 0 && frac < best)
                    begin
                        best = frac;
                        for (int k = 0; k < 3; k++) r.nrm[k] = '0;
                        r.nrm[a] = NRM_NEG;
                    end
                    g = 32'd65536 - frac;
                    if (g < best)
                    begin
                        best = g;
                        for (int k = 0; k < 3; k++) r.nrm[k] = '0;
                        r.nrm[a] = NRM_POS;
                    end
                end
            end
            else
                r.nrm[prev_ax] = neg_step[prev_ax] ? NRM_POS : NRM_NEG;
            for (int a = 0; a < 3; a++)
            begin
                r.cells[a] = cur_cell[a];
                m = longint'((udir[a] < 0) ? -udir[a] : udir[a]) * trav;
                if (udir[a] >= 0) off = m >> UNIT_BITS;
                else off = 32'd0 - 32'((m + 16383) >> UNIT_BITS);
                r.pos[a] = org[a] + off;
            end
            r.hit_dist = trav[23:0];
            active = 1'b0;
            push(r);
            return;
        end
        // step along the nearest boundary; z wins ties, then y
        if (next_x[0] < next_x[1] && next_x[0] < next_x[2]) ax = 0;
        else if (next_x[1] < next_x[2]) ax = 1;
        else ax = 2;
        cur_cell[ax] = neg_step[ax] ? cur_cell[ax] - 16'd1 : cur_cell[ax] + 16'd1;
        trav = next_x[ax];
        next_x[ax] = sat_u32(longint'(next_x[ax]) + longint'(delta[ax]));
        prev_ax = 2'(ax);
        if (trav >= {8'd0, reach})
        begin
            active = 1'b0;
            push(blank(KIND_MISS));
            return;
        end
        r = blank(KIND_QUERY);
        for (int a = 0; a < 3; a++) r.cells[a] = cur_cell[a];
        push(r);
    endtask

    task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_beat();
        walk_result_t e;
        if (result_q.size() == 0)
        begin
            $error("result beat with nothing expected (kind %0d)", result_kind);
            fail_count++;
            return;
        end
        e = result_q.pop_front();
        cmp("result_kind", e.kind, result_kind);
        cmp("cell_x", e.cells[0], cell_x);
        cmp("cell_y", e.cells[1], cell_y);
        cmp("cell_z", e.cells[2], cell_z);
        cmp("normal_x", e.nrm[0], normal_x);
        cmp("normal_y", e.nrm[1], normal_y);
        cmp("normal_z", e.nrm[2], normal_z);
        cmp("hit_distance", e.hit_dist, hit_distance);
        cmp("hit_pos_x", e.pos[0], hit_pos_x);
        cmp("hit_pos_y", e.pos[1], hit_pos_y);
        cmp("hit_pos_z", e.pos[2], hit_pos_z);
        if (e.kind == KIND_HIT) n_hit++;
        else if (e.kind == KIND_MISS) n_miss++;
        else n_query++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach   <= 24'd327680;
            active  <= 1'b0;
            prev_ax <= NO_AXIS;
            trav    <= '0;
            for (int a = 0; a < 3; a++)
            begin
                cur_cell[a] <= '0; next_x[a] <= '0; delta[a] <= '0;
                neg_step[a] <= 1'b0; org[a] <= '0; udir[a] <= 0;
            end
        end
        else
        begin
            if (out_valid && out_ready) check_beat();
            if (cfg_valid && cfg_ready) reach = cfg_data;
            if (in_valid && in_ready) predict_beat();
        end
        pending = result_q.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
        n_query = 0;
        n_hit = 0;
        n_miss = 0;
    end

    final
    begin
    end

endmodule

/* tb/voxel_ray_traversal_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the voxel ray walker: stimulus, handshake pacing and verdict.
module voxel_ray_traversal_tb;
    import vrt_pkg::*;

    localparam int RAY_ITEMS   = 1050;
    localparam int SETTLE      = 700;
    localparam int CYCLE_LIMIT = 4000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic signed [31:0] origin_x, origin_y, origin_z;
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic               voxel_solid;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         result_kind;
    logic signed [15:0] cell_x, cell_y, cell_z;
    logic signed [1:0]  normal_x, normal_y, normal_z;
    logic [23:0]        hit_distance;
    logic signed [31:0] hit_pos_x, hit_pos_y, hit_pos_z;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [23:0]        cfg_data;

    int  fail_count, pending, n_query, n_hit, n_miss;
    int  beats_sent;
    int  cycles;
    bit  pacing;     // random idling on both channels when set

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    voxel_ray_traversal dut (.*);

    voxel_ray_traversal_chk chk (.*);

    // receiver stall: ~37% of cycles while pacing is on
    always @(posedge clk)
        out_ready <= pacing ? ($urandom_range(99) >= 37) : 1'b1;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // One input beat. Valid is only dropped when an idle gap is taken, so it
    // never falls and rises within the same step.
    task automatic send_beat(input logic op, input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [15:0] dx,
                             input logic [15:0] dy, input logic [15:0] dz,
                             input logic solid);
        bit hs;
        while (pacing && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        origin_x    <= ox;
        origin_y    <= oy;
        origin_z    <= oz;
        dir_x       <= dx;
        dir_y       <= dy;
        dir_z       <= dz;
        voxel_solid <= solid;
        do
        begin
            @(negedge clk);
            hs = in_ready;
            @(posedge clk);
        end
        while (!hs);
        beats_sent++;
    endtask

    task automatic start_ray(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [15:0] dx,
                             input logic [15:0] dy, input logic [15:0] dz);
        send_beat(1'b0, ox, oy, oz, dx, dy, dz, 1'b0);
    endtask

    // Answer beat; origin/dir carry junk since only the solid bit matters.
    task automatic answer(input logic solid);
        send_beat(1'b1, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom), solid);
    endtask

    // Register writes only with the block idle and nothing outstanding.
    task automatic set_reach(input logic [23:0] v);
        bit hs;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            hs = cfg_ready;
            @(posedge clk);
        end
        while (!hs);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] near_origin();
        // cell within a few hundred of zero, random fraction
        return {16'($signed($urandom_range(0, 400)) - 16'sd200), 16'($urandom)};
    endfunction

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'($signed($urandom_range(0, 6)) - 16'sd3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Well-formed walk: start, a run of empty cells, usually ending solid.
    task automatic walk();
        int steps;
        start_ray(near_origin(), near_origin(), near_origin(), rand_dir(), rand_dir(),
                  rand_dir());
        steps = $urandom_range(0, 14);
        for (int k = 0; k < steps; k++) answer(1'b0);
        if ($urandom_range(99) < 75) answer(1'b1);
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
                walk();
            else if ($urandom_range(1))
                start_ray($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                          16'($urandom));
            else
                answer(1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        pacing      = 1'b0;
        cycles      = 0;
        beats_sent  = 0;
        in_valid    = 1'b0;
        opcode      = 1'b0;
        origin_x    = '0;
        origin_y    = '0;
        origin_z    = '0;
        dir_x       = '0;
        dir_y       = '0;
        dir_z       = '0;
        voxel_solid = 1'b0;
        out_ready   = 1'b1;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset reach of five cells ---
        answer(1'b1);                                          // no ray yet: ignored
        start_ray(32'h0001_8000, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000); // zero dir
        answer(1'b0);                                          // still no ray
        start_ray(32'h0002_4000, 32'h0001_C000, 32'h0000_F000, 16'sd1, 16'sd2, 16'sd3);
        answer(1'b1);                                          // hit in start cell
        start_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'sd1, 16'sd1, 16'sd1); // ties
        answer(1'b0); answer(1'b0); answer(1'b0); answer(1'b1);
        start_ray(32'h0003_0000, 32'h0, 32'h0, 16'hFFFF, 16'h0, 16'h0); // boundary, negative
        answer(1'b0); answer(1'b1);
        start_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0001, 16'h7FFF, 16'h8000, 16'h7FFF);
        answer(1'b0); answer(1'b0); answer(1'b1);
        start_ray(32'h0000_4000, 32'hFFFF_C000, 32'h0, 16'h8000, 16'h0, 16'h0); // axis-aligned
        for (int k = 0; k < 6; k++) answer(1'b0);              // runs out of reach

        set_reach(24'd0);                                      // every start misses
        start_ray(32'h0000_8000, 32'h0, 32'h0, 16'h0100, 16'hFF00, 16'h0);
        answer(1'b1);

        // --- random, no idling at all ---
        set_reach(24'hFFFFFF);
        random_phase(300);

        // --- random with idling on both sides ---
        pacing = 1'b1;
        set_reach(24'd131072);
        random_phase(250);
        set_reach(24'($urandom));
        random_phase(250);
        set_reach(24'd327680 + 24'($urandom_range(0, 65535)));
        random_phase(220);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("beats sent %0d: %0d queries, %0d hits, %0d misses checked",
                 beats_sent, n_query, n_hit, n_miss);
        $display("reach settings covered zero, reset value, small, random and maximum");
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
